>>> sv/sjtgl_pkg.sv
// shared constants, types and the control store of the text layout sequencer
package sjtgl_pkg;

    localparam int DEF_MAX_GLYPHS = 256;
    localparam int CELL_SIZE      = 24;

    localparam int CODE_W   = 16;
    localparam int WIDTH_W  = 5;
    localparam int ENTRY_W  = CODE_W + WIDTH_W;
    localparam int GCOUNT_W = 9;
    localparam int POS_W    = 16;

    localparam int APB_AW = 2;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] REG_GLYPH_COUNT = 2'd0;

    localparam logic OP_LOAD = 1'b0;

    localparam logic [7:0] BYTE_NUL      = 8'h00;
    localparam logic [7:0] BYTE_NL       = 8'h0A;
    localparam logic [7:0] BYTE_ASCII_LO = 8'h20;
    localparam logic [7:0] BYTE_ASCII_HI = 8'h7F;
    localparam logic [7:0] BYTE_LEAD1_LO = 8'h80;
    localparam logic [7:0] BYTE_LEAD1_HI = 8'h9F;
    localparam logic [7:0] BYTE_LEAD2_LO = 8'hE0;
    localparam logic [7:0] BYTE_LEAD2_HI = 8'hFF;

    typedef enum logic [2:0] {
        CL_LOAD,
        CL_LOOK,
        CL_LEAD,
        CL_NUL,
        CL_NL,
        CL_OTHER
    } t_cls;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_BLANK,
        OUT_END,
        OUT_DRAW
    } t_out_op;

    typedef enum logic [1:0] {
        CUR_KEEP,
        CUR_HOME,
        CUR_NL,
        CUR_ADV
    } t_cur_op;

    typedef enum logic [1:0] {
        LEAD_KEEP,
        LEAD_SET,
        LEAD_CLR
    } t_lead_op;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_ACCEPT,
        C_DISPATCH,
        C_NO_SEARCH,
        C_SCAN_DONE
    } t_cond;

    typedef logic [3:0] t_step;

    localparam t_step S_IDLE = 4'd0;
    localparam t_step S_DEC  = 4'd1;
    localparam t_step S_LOAD = 4'd2;
    localparam t_step S_LEAD = 4'd3;
    localparam t_step S_NUL  = 4'd4;
    localparam t_step S_NL   = 4'd5;
    localparam t_step S_FB0  = 4'd6;
    localparam t_step S_FB1  = 4'd7;
    localparam t_step S_SCAN = 4'd8;
    localparam t_step S_EMIT = 4'd9;

    typedef struct packed {
        logic     in_rdy;
        logic     rd_zero;
        logic     rd_cnt;
        logic     cnt_clr;
        logic     wr_ram;
        logic     take_fb;
        logic     scan;
        t_out_op  out_op;
        t_cur_op  cur_op;
        t_lead_op lead_op;
        t_cond    cond;
        logic     hold;
        t_step    target;
    } t_uword;

    typedef struct packed {
        logic accept;
        logic out_free;
        logic no_search;
        logic scan_done;
        t_cls cls;
    } t_seq_stat;

    function automatic t_uword uc_rom(input t_step s);
        t_uword w;
        w        = '0;
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
        case (s)
            S_IDLE: begin
                w.in_rdy  = 1'b1;
                w.cnt_clr = 1'b1;
                w.cond    = C_ACCEPT;
                w.hold    = 1'b1;
                w.target  = S_DEC;
            end
            S_DEC: begin
                w.cond = C_DISPATCH;
            end
            S_LOAD: begin
                w.wr_ram = 1'b1;
                w.out_op = OUT_BLANK;
            end
            S_LEAD: begin
                w.lead_op = LEAD_SET;
                w.out_op  = OUT_BLANK;
            end
            S_NUL: begin
                w.cur_op = CUR_HOME;
                w.out_op = OUT_END;
            end
            S_NL: begin
                w.cur_op = CUR_NL;
                w.out_op = OUT_BLANK;
            end
            S_FB0: begin
                w.rd_zero = 1'b1;
                w.lead_op = LEAD_CLR;
                w.target  = S_FB1;
            end
            S_FB1: begin
                w.take_fb = 1'b1;
                w.rd_cnt  = 1'b1;
                w.cond    = C_NO_SEARCH;
                w.target  = S_EMIT;
            end
            S_SCAN: begin
                w.scan   = 1'b1;
                w.rd_cnt = 1'b1;
                w.cond   = C_SCAN_DONE;
                w.hold   = 1'b1;
                w.target = S_EMIT;
            end
            S_EMIT: begin
                w.out_op = OUT_DRAW;
                w.cur_op = CUR_ADV;
            end
            default: begin
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic t_step dispatch_target(input t_cls c);
        t_step t;
        case (c)
            CL_LOAD:  t = S_LOAD;
            CL_LEAD:  t = S_LEAD;
            CL_NUL:   t = S_NUL;
            CL_NL:    t = S_NL;
            default:  t = S_FB0;
        endcase
        return t;
    endfunction

endpackage

>>> sv/sjtgl_ifs.sv
// stream interfaces for message beats and layout result beats
interface sjtgl_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] entry_index;
    logic [15:0] glyph_code;
    logic [4:0] glyph_width;
    logic [7:0] text_byte;

    modport source (
        output valid, operation, entry_index, glyph_code, glyph_width, text_byte,
        input  ready
    );
    modport sink (
        input  valid, operation, entry_index, glyph_code, glyph_width, text_byte,
        output ready
    );
endinterface

interface sjtgl_out_if;
    logic               valid;
    logic               ready;
    logic               draw;
    logic [7:0]         glyph_index;
    logic               found;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               message_end;

    modport source (
        output valid, draw, glyph_index, found, pos_x, pos_y, message_end,
        input  ready
    );
    modport sink (
        input  valid, draw, glyph_index, found, pos_x, pos_y, message_end,
        output ready
    );
endinterface

>>> sv/sjtgl_ram.sv
// generic single write port, single read port ram with registered read
module sjtgl_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/sjtgl_seq.sv
// step counter and control store of the layout sequencer
module sjtgl_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sjtgl_pkg::t_seq_stat i_stat,
    output sjtgl_pkg::t_uword   o_uw
);

    sjtgl_pkg::t_step  r_step;
    sjtgl_pkg::t_step  n_step;
    sjtgl_pkg::t_uword w_uw;
    logic              w_taken;

    assign w_uw = sjtgl_pkg::uc_rom(r_step);
    assign o_uw = w_uw;

    always_comb begin
        case (w_uw.cond)
            sjtgl_pkg::C_ALWAYS:    w_taken = 1'b1;
            sjtgl_pkg::C_ACCEPT:    w_taken = i_stat.accept;
            sjtgl_pkg::C_DISPATCH:  w_taken = 1'b1;
            sjtgl_pkg::C_NO_SEARCH: w_taken = i_stat.no_search;
            sjtgl_pkg::C_SCAN_DONE: w_taken = i_stat.scan_done;
            default:                w_taken = 1'b1;
        endcase
    end

    always_comb begin
        n_step = r_step;
        // a step that writes a result beat waits for the output register
        if (w_uw.out_op == sjtgl_pkg::OUT_NONE || i_stat.out_free) begin
            if (w_uw.cond == sjtgl_pkg::C_DISPATCH) begin
                n_step = sjtgl_pkg::dispatch_target(i_stat.cls);
            end else if (w_taken) begin
                n_step = w_uw.target;
            end else if (!w_uw.hold) begin
                n_step = r_step + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= sjtgl_pkg::S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

>>> sv/sjis_text_glyph_layout.sv
// top level: shift-jis text layout with glyph table lookup
// Each beat on i_txt gives exactly one beat on o_res. A table load, a lead
// byte, a newline or a NUL passes the idle and decode steps, and then its own
// step writes the result register; a drawn glyph reads entry 0 as fallback,
// then compares k table entries (1 up to min(glyph_count, MAX_GLYPHS)) in a
// linear search that reads one table entry per cycle from the single read port
// of the glyph ram; a fallback glyph (other control byte or empty table) skips the search.
// One beat is worked on at a time and a new beat is taken once the sequencer
// is back in its idle step, while the previous result may still wait to be
// taken. glyph_count is written over the APB port at byte address 0 and must
// only change while the block is idle. Every table entry that a search or a
// fallback reaches has to be loaded first; there is no clearing pass.
module sjis_text_glyph_layout #(
    parameter int MAX_GLYPHS = sjtgl_pkg::DEF_MAX_GLYPHS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sjtgl_in_if.sink                      i_txt,
    sjtgl_out_if.source                   o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sjtgl_pkg::APB_AW-1:0]  paddr,
    input  logic [sjtgl_pkg::APB_DW-1:0]  pwdata,
    output logic [sjtgl_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);

    localparam int IDX_W = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
    localparam int CNT_W = $clog2(MAX_GLYPHS + 1);
    localparam int CMP_W = (CNT_W > sjtgl_pkg::GCOUNT_W) ? CNT_W : sjtgl_pkg::GCOUNT_W;

    sjtgl_pkg::t_uword    w_uw;
    sjtgl_pkg::t_seq_stat w_stat;

    logic [sjtgl_pkg::GCOUNT_W-1:0] r_gcount;

    logic [7:0]                     r_entry;
    logic [sjtgl_pkg::CODE_W-1:0]   r_gcode;
    logic [sjtgl_pkg::WIDTH_W-1:0]  r_gwidth;
    logic [7:0]                     r_byte;
    logic [sjtgl_pkg::CODE_W-1:0]   r_key;
    sjtgl_pkg::t_cls                r_cls;

    logic [CNT_W-1:0]               r_cnt;
    logic                           r_hit;
    logic [IDX_W-1:0]               r_idx;
    logic [sjtgl_pkg::WIDTH_W-1:0]  r_w;

    logic [sjtgl_pkg::POS_W-1:0]    r_cur_x;
    logic [sjtgl_pkg::POS_W-1:0]    r_cur_y;
    logic                           r_lead_pend;
    logic [7:0]                     r_lead_byte;

    logic                           r_o_valid;
    logic                           r_o_draw;
    logic [7:0]                     r_o_idx;
    logic                           r_o_found;
    logic [sjtgl_pkg::POS_W-1:0]    r_o_x;
    logic [sjtgl_pkg::POS_W-1:0]    r_o_y;
    logic                           r_o_end;

    logic                           w_accept;
    logic                           w_out_free;
    logic                           w_fire;
    sjtgl_pkg::t_cls                w_cls;
    logic [sjtgl_pkg::CODE_W-1:0]   w_key;
    logic [CMP_W-1:0]               w_limit;
    logic [CMP_W-1:0]               w_slot;
    logic                           w_slot_ok;
    logic [CMP_W-1:0]               w_idx_ext;
    logic [IDX_W-1:0]               w_raddr;
    logic                           w_re;
    logic                           w_we;
    logic [sjtgl_pkg::ENTRY_W-1:0]  w_rdata;
    logic [sjtgl_pkg::CODE_W-1:0]   w_rcode;
    logic [sjtgl_pkg::WIDTH_W-1:0]  w_rwidth;
    logic                           w_match;
    logic                           w_cfg_wr;

    // ---------------------------------------------------------------- config
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr == sjtgl_pkg::REG_GLYPH_COUNT);
    assign prdata   = (paddr == sjtgl_pkg::REG_GLYPH_COUNT)
                    ? sjtgl_pkg::APB_DW'(r_gcount) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gcount <= '0;
        end else if (w_cfg_wr) begin
            r_gcount <= pwdata[sjtgl_pkg::GCOUNT_W-1:0];
        end
    end

    // ---------------------------------------------------------------- sequencer
    sjtgl_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_uw    (w_uw)
    );

    assign i_txt.ready = w_uw.in_rdy;
    assign w_accept    = i_txt.valid && w_uw.in_rdy;
    assign w_out_free  = !r_o_valid || o_res.ready;
    assign w_fire      = (w_uw.out_op == sjtgl_pkg::OUT_NONE) || w_out_free;

    // byte class as seen at acceptance
    always_comb begin
        if (i_txt.operation == sjtgl_pkg::OP_LOAD) begin
            w_cls = sjtgl_pkg::CL_LOAD;
        end else if (r_lead_pend) begin
            w_cls = sjtgl_pkg::CL_LOOK;
        end else if (i_txt.text_byte inside
                     {[sjtgl_pkg::BYTE_ASCII_LO:sjtgl_pkg::BYTE_ASCII_HI]}) begin
            w_cls = sjtgl_pkg::CL_LOOK;
        end else if (i_txt.text_byte inside
                     {[sjtgl_pkg::BYTE_LEAD1_LO:sjtgl_pkg::BYTE_LEAD1_HI],
                      [sjtgl_pkg::BYTE_LEAD2_LO:sjtgl_pkg::BYTE_LEAD2_HI]}) begin
            w_cls = sjtgl_pkg::CL_LEAD;
        end else if (i_txt.text_byte == sjtgl_pkg::BYTE_NUL) begin
            w_cls = sjtgl_pkg::CL_NUL;
        end else if (i_txt.text_byte == sjtgl_pkg::BYTE_NL) begin
            w_cls = sjtgl_pkg::CL_NL;
        end else begin
            w_cls = sjtgl_pkg::CL_OTHER;
        end
    end

    assign w_key = r_lead_pend ? {r_lead_byte, i_txt.text_byte} : {8'h00, i_txt.text_byte};

    assign w_limit = (CMP_W'(r_gcount) > CMP_W'(MAX_GLYPHS))
                   ? CMP_W'(MAX_GLYPHS) : CMP_W'(r_gcount);

    assign w_rcode  = w_rdata[sjtgl_pkg::ENTRY_W-1:sjtgl_pkg::WIDTH_W];
    assign w_rwidth = w_rdata[sjtgl_pkg::WIDTH_W-1:0];
    assign w_match  = (w_rcode == r_key);

    assign w_stat.accept    = w_accept;
    assign w_stat.out_free  = w_out_free;
    assign w_stat.no_search = (r_cls == sjtgl_pkg::CL_OTHER) || (r_gcount == '0);
    assign w_stat.scan_done = w_match || (CMP_W'(r_cnt) == w_limit);
    assign w_stat.cls       = r_cls;

    // ---------------------------------------------------------------- glyph ram
    assign w_slot    = CMP_W'(r_entry);
    assign w_slot_ok = w_slot < CMP_W'(MAX_GLYPHS);
    assign w_we      = w_uw.wr_ram && w_fire && w_slot_ok;
    assign w_re      = w_uw.rd_zero || w_uw.rd_cnt;
    assign w_raddr   = w_uw.rd_zero ? '0 : r_cnt[IDX_W-1:0];

    sjtgl_ram #(
        .WIDTH (sjtgl_pkg::ENTRY_W),
        .DEPTH (MAX_GLYPHS)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_slot[IDX_W-1:0]),
        .i_wdata ({r_gcode, r_gwidth}),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_entry  <= i_txt.entry_index;
            r_gcode  <= i_txt.glyph_code;
            r_gwidth <= i_txt.glyph_width;
            r_byte   <= i_txt.text_byte;
            r_key    <= w_key;
            r_cls    <= w_cls;
        end
        if (w_uw.cnt_clr) begin
            r_cnt <= '0;
        end else if (w_uw.rd_cnt) begin
            r_cnt <= r_cnt + 1'b1;
        end
        // fallback entry 0 first, a match found later overrides it
        if (w_uw.take_fb) begin
            r_hit <= 1'b0;
            r_idx <= '0;
            r_w   <= w_rwidth;
        end else if (w_uw.scan && w_match) begin
            r_hit <= 1'b1;
            r_idx <= IDX_W'(r_cnt - 1'b1);
            r_w   <= w_rwidth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_lead_pend <= 1'b0;
            r_lead_byte <= '0;
        end else if (w_fire) begin
            case (w_uw.cur_op)
                sjtgl_pkg::CUR_HOME: begin
                    r_cur_x <= '0;
                    r_cur_y <= '0;
                end
                sjtgl_pkg::CUR_NL: begin
                    r_cur_x <= '0;
                    r_cur_y <= r_cur_y - sjtgl_pkg::POS_W'(sjtgl_pkg::CELL_SIZE);
                end
                sjtgl_pkg::CUR_ADV: begin
                    r_cur_x <= r_cur_x + sjtgl_pkg::POS_W'(r_w);
                end
                default: begin
                end
            endcase
            case (w_uw.lead_op)
                sjtgl_pkg::LEAD_SET: begin
                    r_lead_pend <= 1'b1;
                    r_lead_byte <= r_byte;
                end
                sjtgl_pkg::LEAD_CLR: begin
                    r_lead_pend <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- result register
    assign w_idx_ext = CMP_W'(r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_uw.out_op != sjtgl_pkg::OUT_NONE && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_uw.out_op != sjtgl_pkg::OUT_NONE && w_out_free) begin
            if (w_uw.out_op == sjtgl_pkg::OUT_DRAW) begin
                r_o_draw  <= 1'b1;
                r_o_idx   <= w_idx_ext[7:0];
                r_o_found <= r_hit;
                r_o_x     <= r_cur_x;
                r_o_y     <= r_cur_y;
            end else begin
                r_o_draw  <= 1'b0;
                r_o_idx   <= '0;
                r_o_found <= 1'b0;
                r_o_x     <= '0;
                r_o_y     <= '0;
            end
            r_o_end <= (w_uw.out_op == sjtgl_pkg::OUT_END);
        end
    end

    assign o_res.valid       = r_o_valid;
    assign o_res.draw        = r_o_draw;
    assign o_res.glyph_index = r_o_idx;
    assign o_res.found       = r_o_found;
    assign o_res.pos_x       = $signed(r_o_x);
    assign o_res.pos_y       = $signed(r_o_y);
    assign o_res.message_end = r_o_end;

endmodule
